>>> hw/rtl/pbe_pkg.sv
// Package for the planar body Euler step unit.
// Holds shared widths, fixed-point constants, codes and control types.
// Used by pbe_mul, pbe_csu and planar_body_euler_step_unit.
package pbe_pkg;

    localparam int MUL_W     = 48;
    localparam int PROD_W    = 96;
    localparam int PROD_OUT_W = 64;
    localparam int MAG_W     = 47;
    localparam int CSU_SRC_W = 66;
    localparam int CSU_DVS_W = 42;
    localparam int CSU_CNT_W = 7;

    localparam logic [MAG_W-1:0] MAG_CAP = '1;
    localparam logic [19:0]      GRAV_Q  = 20'd642908;
    localparam logic [15:0]      DRAG_Q  = 16'd37733;
    localparam logic [9:0]       DT_DIV  = 10'd1000;

    // Multiplying a value below 2^32 by DT_RECIP and shifting right by DT_RECIP_SH
    // gives the exact floor of the value divided by 1000.
    localparam logic [28:0]      DT_RECIP    = 29'h1062_4DD3;
    localparam int               DT_RECIP_SH = 38;

    localparam logic [CSU_CNT_W-1:0] ROOT_STEPS = 7'd32;
    localparam logic [CSU_CNT_W-1:0] UDIV_STEPS = 7'd48;
    localparam logic [CSU_CNT_W-1:0] FDIV_STEPS = 7'd65;

    typedef enum logic [1:0] {
        OP_STEP     = 2'd0,
        OP_LOAD_POS = 2'd1,
        OP_LOAD_VEL = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_MASS     = 2'd0,
        REG_FRICTION = 2'd1,
        REG_RADIUS   = 2'd2,
        REG_HEIGHT   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CSU_DIV  = 1'b0,
        CSU_SQRT = 1'b1
    } csu_mode_t;

    typedef struct packed {
        logic                 start;
        csu_mode_t            mode;
        logic [CSU_CNT_W-1:0] count;
    } csu_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEN,
        ST_SQ0,
        ST_SQ1,
        ST_ROOT,
        ST_FM1,
        ST_FM2,
        ST_AR1,
        ST_AR2,
        ST_DK,
        ST_UDIV,
        ST_FRIC,
        ST_DRAG,
        ST_FDIV,
        ST_PDIV,
        ST_OUT
    } state_t;

endpackage

>>> hw/rtl/pbe_mul.sv
// Iterative 48 x 48 multiplier, one 48 x 16 partial product per cycle.
// Gives the low 64 product bits and the fixed-point product (shifted right by 16) saturated to unsigned Q31.16.
// Depends on pbe_pkg.
module pbe_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pbe_pkg::MUL_W-1:0]      a,
    input  logic [pbe_pkg::MUL_W-1:0]      b,
    output logic                           done,
    output logic [pbe_pkg::PROD_OUT_W-1:0] prod,
    output logic [pbe_pkg::MAG_W-1:0]      sat_prod
);
    import pbe_pkg::*;

    logic [MUL_W-1:0]  a_reg, a_next;
    logic [MUL_W-1:0]  b_reg, b_next;
    logic [63:0]       pp_reg, pp_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [1:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [15:0]       chunk;
    logic [PROD_W-1:0] pp_shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        case (step_reg)
            2'd0:    chunk = b_reg[15:0];
            2'd1:    chunk = b_reg[31:16];
            2'd2:    chunk = b_reg[47:32];
            default: chunk = 16'd0;
        endcase
        case (step_reg)
            2'd1:    pp_shifted = {32'd0, pp_reg};
            2'd2:    pp_shifted = {16'd0, pp_reg, 16'd0};
            2'd3:    pp_shifted = {pp_reg, 32'd0};
            default: pp_shifted = '0;
        endcase

        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
            step_next = 2'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            pp_next   = 64'(a_reg) * 64'(chunk);
            acc_next  = acc_reg + pp_shifted;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign prod     = acc_reg[PROD_OUT_W-1:0];
    assign sat_prod = (|acc_reg[PROD_W-1:63]) ? MAG_CAP : acc_reg[62:16];

endmodule

>>> hw/rtl/pbe_csu.sv
// Shared compare-subtract unit: restoring division at one quotient bit per
// cycle, or integer square root at one root bit per cycle.
// Depends on pbe_pkg.
module pbe_csu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pbe_pkg::csu_req_t             req,
    input  logic [pbe_pkg::CSU_SRC_W-1:0] src,
    input  logic [pbe_pkg::CSU_DVS_W-1:0] dvs,
    output logic                          done,
    output logic [pbe_pkg::CSU_SRC_W-1:0] quot
);
    import pbe_pkg::*;

    logic [CSU_SRC_W-1:0] src_reg, src_next;
    logic [CSU_SRC_W-1:0] q_reg, q_next;
    logic [CSU_DVS_W-1:0] dvs_reg, dvs_next;
    logic [CSU_DVS_W-1:0] rem_reg, rem_next;
    logic [CSU_CNT_W-1:0] cnt_reg, cnt_next;
    csu_mode_t            mode_reg, mode_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CSU_DVS_W:0]   shifted;
    logic [CSU_DVS_W:0]   trial;
    logic [CSU_DVS_W+1:0] diff;
    logic                 ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        src_reg  <= src_next;
        q_reg    <= q_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        mode_reg <= mode_next;
    end

    always_comb begin
        if (mode_reg == CSU_SQRT) begin
            shifted = {rem_reg[CSU_DVS_W-2:0], src_reg[CSU_SRC_W-1 -: 2]};
            trial   = {9'd0, q_reg[31:0], 2'b01};
        end else begin
            shifted = {rem_reg, src_reg[CSU_SRC_W-1]};
            trial   = {1'b0, dvs_reg};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = ~diff[CSU_DVS_W+1];

        src_next  = src_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start) begin
            src_next  = src;
            dvs_next  = dvs;
            mode_next = req.mode;
            cnt_next  = req.count;
            q_next    = '0;
            rem_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[CSU_DVS_W-1:0] : shifted[CSU_DVS_W-1:0];
            q_next   = {q_reg[CSU_SRC_W-2:0], ge};
            src_next = (mode_reg == CSU_SQRT) ? {src_reg[CSU_SRC_W-3:0], 2'b00}
                                              : {src_reg[CSU_SRC_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> hw/rtl/planar_body_euler_step_unit.sv
// Planar body Euler step unit: position and velocity in Q16.16, one step, load or no-operation per item.
// A step of a moving body also runs the speed, friction and drag states, which a body at rest skips;
// steps use the shared one-bit-per-cycle divide/square-root unit and the 48 x 16 multiplier.
// One item is in work at a time; the next is taken while the last result waits at the output.
// Synchronous active-low reset zeroes position and velocity and restores the register defaults.
// Depends on pbe_pkg, pbe_mul and pbe_csu.
module planar_body_euler_step_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // operation[1:0], value_x[33:2], value_y[65:34], zero
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96]
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_wdata
);
    import pbe_pkg::*;

    state_t              state_reg, state_next;
    logic                issued_reg, issued_next;
    logic                comp_reg, comp_next;
    logic signed [31:0]  pos_reg [2];
    logic signed [31:0]  pos_next [2];
    logic signed [31:0]  vel_reg [2];
    logic signed [31:0]  vel_next [2];
    logic signed [49:0]  force_reg [2];
    logic signed [49:0]  force_next [2];
    logic [31:0]         m_reg [2];
    logic [31:0]         m_next [2];
    logic [30:0]         mass_reg, mass_next;
    logic [30:0]         fric_reg, fric_next;
    logic [30:0]         rad_reg, rad_next;
    logic [30:0]         hgt_reg, hgt_next;
    logic [40:0]         den_reg, den_next;
    logic [63:0]         sum_reg, sum_next;
    logic [31:0]         speed_reg, speed_next;
    logic [MAG_W-1:0]    fmag_reg, fmag_next;
    logic [MAG_W-1:0]    tmp_reg, tmp_next;
    logic [MAG_W-1:0]    dk_reg, dk_next;
    logic [16:0]         u_reg, u_next;
    logic [MAG_W:0]      res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [127:0]        m_tdata_reg, m_tdata_next;

    logic                    mul_start;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic                    mul_done;
    logic [PROD_OUT_W-1:0]   mul_prod;
    logic [MAG_W-1:0]        mul_sat;
    csu_req_t                csu_req;
    logic [CSU_SRC_W-1:0]    csu_src;
    logic [CSU_DVS_W-1:0]    csu_dvs;
    logic                    csu_done;
    logic [CSU_SRC_W-1:0]    csu_quot;

    op_t                 in_op;
    logic signed [31:0]  in_x;
    logic signed [31:0]  in_y;
    logic [30:0]         mass_eff;
    logic [MAG_W:0]      res_sum;
    logic [48:0]         f_mag;
    logic [31:0]         nv_mag;
    logic signed [34:0]  vel_sum;
    logic signed [34:0]  pos_sum;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
            sat32 = x[31:0];
        end else if (x[34]) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'sh7FFF_FFFF;
        end
    endfunction

    pbe_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod     (mul_prod),
        .sat_prod (mul_sat)
    );

    pbe_csu u_csu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (csu_req),
        .src     (csu_src),
        .dvs     (csu_dvs),
        .done    (csu_done),
        .quot    (csu_quot)
    );

    assign in_op    = op_t'(s_tdata[1:0]);
    assign in_x     = s_tdata[33:2];
    assign in_y     = s_tdata[65:34];
    assign mass_eff = (mass_reg == 31'd0) ? 31'd1 : mass_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            comp_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            vel_reg[0]   <= '0;
            vel_reg[1]   <= '0;
            mass_reg     <= 31'd65536;
            fric_reg     <= '0;
            rad_reg      <= '0;
            hgt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            comp_reg     <= comp_next;
            m_tvalid_reg <= m_tvalid_next;
            pos_reg      <= pos_next;
            vel_reg      <= vel_next;
            mass_reg     <= mass_next;
            fric_reg     <= fric_next;
            rad_reg      <= rad_next;
            hgt_reg      <= hgt_next;
        end
        force_reg   <= force_next;
        m_reg       <= m_next;
        den_reg     <= den_next;
        sum_reg     <= sum_next;
        speed_reg   <= speed_next;
        fmag_reg    <= fmag_next;
        tmp_reg     <= tmp_next;
        dk_reg      <= dk_next;
        u_reg       <= u_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        state_next    = state_reg;
        issued_next   = issued_reg;
        comp_next     = comp_reg;
        pos_next      = pos_reg;
        vel_next      = vel_reg;
        force_next    = force_reg;
        m_next        = m_reg;
        mass_next     = mass_reg;
        fric_next     = fric_reg;
        rad_next      = rad_reg;
        hgt_next      = hgt_reg;
        den_next      = den_reg;
        sum_next      = sum_reg;
        speed_next    = speed_reg;
        fmag_next     = fmag_reg;
        tmp_next      = tmp_reg;
        dk_next       = dk_reg;
        u_next        = u_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        csu_req.start = 1'b0;
        csu_req.mode  = CSU_DIV;
        csu_req.count = '0;
        csu_src       = '0;
        csu_dvs       = '0;

        res_sum = res_reg + {1'b0, mul_sat};
        f_mag   = force_reg[comp_reg][49] ? 49'(-force_reg[comp_reg])
                                          : force_reg[comp_reg][48:0];
        nv_mag  = abs32(vel_reg[comp_reg]);
        if (force_reg[comp_reg][49]) begin
            vel_sum = 35'(vel_reg[comp_reg]) - $signed({2'b00, csu_quot[32:0]});
        end else begin
            vel_sum = 35'(vel_reg[comp_reg]) + $signed({2'b00, csu_quot[32:0]});
        end
        if (vel_reg[comp_reg][31]) begin
            pos_sum = 35'(pos_reg[comp_reg])
                      - $signed(35'(mul_prod[PROD_OUT_W-1:DT_RECIP_SH]));
        end else begin
            pos_sum = 35'(pos_reg[comp_reg])
                      + $signed(35'(mul_prod[PROD_OUT_W-1:DT_RECIP_SH]));
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MASS:     mass_next = cfg_wdata;
                REG_FRICTION: fric_next = cfg_wdata;
                REG_RADIUS:   rad_next  = cfg_wdata;
                REG_HEIGHT:   hgt_next  = cfg_wdata;
                default:      mass_next = mass_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_STEP: begin
                            force_next[0] = 50'(in_x);
                            force_next[1] = 50'(in_y);
                            m_next[0]     = abs32(vel_reg[0]);
                            m_next[1]     = abs32(vel_reg[1]);
                            state_next    = ST_DEN;
                        end
                        OP_LOAD_POS: begin
                            pos_next[0] = in_x;
                            pos_next[1] = in_y;
                            state_next  = ST_OUT;
                        end
                        OP_LOAD_VEL: begin
                            vel_next[0] = in_x;
                            vel_next[1] = in_y;
                            state_next  = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DEN: begin
                mul_a = 48'(mass_eff);
                mul_b = 48'(DT_DIV);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    den_next    = mul_prod[40:0];
                    comp_next   = 1'b0;
                    state_next  = (m_reg[0] != 32'd0 || m_reg[1] != 32'd0) ? ST_SQ0 : ST_FDIV;
                end
            end
            ST_SQ0: begin
                mul_a = 48'(m_reg[0]);
                mul_b = 48'(m_reg[0]);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    sum_next    = mul_prod;
                    state_next  = ST_SQ1;
                end
            end
            ST_SQ1: begin
                mul_a = 48'(m_reg[1]);
                mul_b = 48'(m_reg[1]);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    sum_next    = sum_reg + mul_prod;
                    state_next  = ST_ROOT;
                end
            end
            ST_ROOT: begin
                csu_req.mode  = CSU_SQRT;
                csu_req.count = ROOT_STEPS;
                csu_src       = {sum_reg, 2'b00};
                if (!issued_reg) begin
                    csu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (csu_done) begin
                    issued_next = 1'b0;
                    speed_next  = csu_quot[31:0];
                    state_next  = ST_FM1;
                end
            end
            ST_FM1: begin
                mul_a = 48'(mass_eff);
                mul_b = 48'(fric_reg);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = mul_sat;
                    state_next  = ST_FM2;
                end
            end
            ST_FM2: begin
                mul_a = 48'(tmp_reg);
                mul_b = 48'(GRAV_Q);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    fmag_next   = mul_sat;
                    state_next  = ST_AR1;
                end
            end
            ST_AR1: begin
                mul_a = 48'(rad_reg);
                mul_b = 48'(hgt_reg);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = mul_sat;
                    state_next  = ST_AR2;
                end
            end
            ST_AR2: begin
                mul_a = 48'(tmp_reg);
                mul_b = 48'(DRAG_Q);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    tmp_next    = mul_sat;
                    state_next  = ST_DK;
                end
            end
            ST_DK: begin
                mul_a = 48'(tmp_reg);
                mul_b = 48'(speed_reg);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    dk_next     = mul_sat;
                    comp_next   = 1'b0;
                    state_next  = ST_UDIV;
                end
            end
            ST_UDIV: begin
                csu_req.mode  = CSU_DIV;
                csu_req.count = UDIV_STEPS;
                csu_src       = {m_reg[comp_reg], 34'd0};
                csu_dvs       = 42'(speed_reg);
                if (!issued_reg) begin
                    csu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (csu_done) begin
                    issued_next = 1'b0;
                    u_next      = csu_quot[16:0];
                    state_next  = ST_FRIC;
                end
            end
            ST_FRIC: begin
                mul_a = 48'(fmag_reg);
                mul_b = 48'(u_reg);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    res_next    = {1'b0, mul_sat};
                    state_next  = ST_DRAG;
                end
            end
            ST_DRAG: begin
                mul_a = 48'(dk_reg);
                mul_b = 48'(m_reg[comp_reg]);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    if (vel_reg[comp_reg][31]) begin
                        force_next[comp_reg] = force_reg[comp_reg] + $signed({2'b00, res_sum});
                    end else begin
                        force_next[comp_reg] = force_reg[comp_reg] - $signed({2'b00, res_sum});
                    end
                    if (!comp_reg) begin
                        comp_next  = 1'b1;
                        state_next = ST_UDIV;
                    end else begin
                        comp_next  = 1'b0;
                        state_next = ST_FDIV;
                    end
                end
            end
            ST_FDIV: begin
                csu_req.mode  = CSU_DIV;
                csu_req.count = FDIV_STEPS;
                csu_src       = {f_mag, 17'd0};
                csu_dvs       = {1'b0, den_reg};
                if (!issued_reg) begin
                    csu_req.start = 1'b1;
                    issued_next   = 1'b1;
                end else if (csu_done) begin
                    issued_next = 1'b0;
                    if (|csu_quot[CSU_SRC_W-1:33]) begin
                        vel_next[comp_reg] = force_reg[comp_reg][49] ? 32'sh8000_0000
                                                                     : 32'sh7FFF_FFFF;
                    end else begin
                        vel_next[comp_reg] = sat32(vel_sum);
                    end
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                mul_a = 48'(nv_mag);
                mul_b = 48'(DT_RECIP);
                if (!issued_reg) begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mul_done) begin
                    issued_next        = 1'b0;
                    pos_next[comp_reg] = sat32(pos_sum);
                    if (!comp_reg) begin
                        comp_next  = 1'b1;
                        state_next = ST_FDIV;
                    end else begin
                        comp_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {vel_reg[1], vel_reg[0], pos_reg[1], pos_reg[0]};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/sv/body_state_checker.sv
`timescale 1ns / 100ps
// Checker for the planar body Euler step unit: watches the item, result and register ports,
// predicts the body state after every accepted item and compares it with each result.
// Depends on pbe_pkg for the operation and register index codes.
module body_state_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [71:0]   s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [127:0]  m_tdata,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_wdata,
    output int            fail_count,
    output int            pending
);
    import pbe_pkg::*;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } body_state_t;

    localparam logic [63:0] GRAVITY_Q = 64'd642908;
    localparam logic [63:0] DRAG_K_Q  = 64'd37733;
    localparam logic [63:0] FORCE_CAP = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint      STEP_DIV  = 1000;
    localparam longint      S32_MAX   = 64'sd2147483647;
    localparam longint      S32_MIN   = -64'sd2147483648;

    logic [30:0]        mass_r;
    logic [30:0]        mu_r;
    logic [30:0]        radius_r;
    logic [30:0]        height_r;
    logic signed [31:0] pos_q [2];
    logic signed [31:0] vel_q [2];
    body_state_t        expected_states [$];
    int                 result_no;

    function automatic logic [63:0] qmul_sat(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = (128'(a) * 128'(b)) >> 16;
        return (prod > 128'(FORCE_CAP)) ? FORCE_CAP : prod[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Force times 65536 over the divisor, truncated toward zero.
    function automatic longint div_by_mass(input longint f, input logic [63:0] den);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] res;
        mag = (f < 0) ? 64'(-f) : 64'(f);
        q   = mag / den;
        r   = mag % den;
        res = (q << 16) + ((r << 16) / den);
        return (f < 0) ? -longint'(res) : longint'(res);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        if (v < S32_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic body_state_t advance_body(input op_t op, input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        longint             vel [2];
        longint             push_f [2];
        logic [63:0]        mag [2];
        logic [63:0]        mass_eff;
        logic [63:0]        den;
        logic [63:0]        speed;
        logic [63:0]        fmag;
        logic [63:0]        area;
        logic [63:0]        dk;
        logic [63:0]        unit;
        logic [63:0]        resist;
        logic signed [31:0] nv;
        body_state_t        st;
        case (op)
            OP_LOAD_POS: begin
                pos_q[0] = x;
                pos_q[1] = y;
            end
            OP_LOAD_VEL: begin
                vel_q[0] = x;
                vel_q[1] = y;
            end
            OP_STEP: begin
                mass_eff  = (mass_r == 0) ? 64'd1 : 64'(mass_r);
                den       = mass_eff * 64'(STEP_DIV);
                vel[0]    = vel_q[0];
                vel[1]    = vel_q[1];
                push_f[0] = x;
                push_f[1] = y;
                for (int c = 0; c < 2; c++) mag[c] = (vel[c] < 0) ? 64'(-vel[c]) : 64'(vel[c]);
                if (vel[0] != 0 || vel[1] != 0) begin
                    speed = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1]);
                    fmag  = qmul_sat(qmul_sat(mass_eff, 64'(mu_r)), GRAVITY_Q);
                    area  = qmul_sat(qmul_sat(64'(radius_r), 64'(height_r)), DRAG_K_Q);
                    dk    = qmul_sat(area, speed);
                    for (int c = 0; c < 2; c++) begin
                        unit   = (mag[c] << 16) / speed;
                        resist = qmul_sat(fmag, unit) + qmul_sat(dk, mag[c]);
                        if (vel[c] > 0) push_f[c] -= longint'(resist);
                        else if (vel[c] < 0) push_f[c] += longint'(resist);
                    end
                end
                for (int c = 0; c < 2; c++) begin
                    nv       = clamp32(vel[c] + div_by_mass(push_f[c], den));
                    vel_q[c] = nv;
                    pos_q[c] = clamp32(longint'(pos_q[c]) + longint'(nv) / STEP_DIV);
                end
            end
            default: ;
        endcase
        st.pos_x = pos_q[0];
        st.pos_y = pos_q[1];
        st.vel_x = vel_q[0];
        st.vel_y = vel_q[1];
        return st;
    endfunction

    always @(posedge aclk) begin
        body_state_t want;
        body_state_t got;
        if (!aresetn) begin
            mass_r     = 31'd65536;
            mu_r       = '0;
            radius_r   = '0;
            height_r   = '0;
            pos_q      = '{32'sd0, 32'sd0};
            vel_q      = '{32'sd0, 32'sd0};
            result_no  = 0;
            fail_count = 0;
            expected_states.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MASS:     mass_r   = cfg_wdata;
                    REG_FRICTION: mu_r     = cfg_wdata;
                    REG_RADIUS:   radius_r = cfg_wdata;
                    REG_HEIGHT:   height_r = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_states.push_back(advance_body(op_t'(s_tdata[1:0]), s_tdata[33:2],
                                                       s_tdata[65:34]));
            end
            if (m_tvalid && m_tready) begin
                got.pos_x = m_tdata[31:0];
                got.pos_y = m_tdata[63:32];
                got.vel_x = m_tdata[95:64];
                got.vel_y = m_tdata[127:96];
                if (expected_states.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with no item waiting for it", result_no);
                end else begin
                    want = expected_states.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: expected pos (%0d, %0d) vel (%0d, %0d),",
                                     result_no, want.pos_x, want.pos_y, want.vel_x,
                                     want.vel_y, " got pos (%0d, %0d) vel (%0d, %0d)",
                                     got.pos_x, got.pos_y, got.vel_x, got.vel_y);
                    end
                end
                result_no++;
            end
            pending <= expected_states.size();
        end
    end

endmodule

>>> tb/sv/tb_planar_body_euler_step_unit.sv
`timescale 1ns / 100ps
// Top of the testbench for the planar body Euler step unit: clock, reset, item stimulus,
// register settings and output stalls; the verdict comes from body_state_checker.
// Depends on pbe_pkg, planar_body_euler_step_unit and body_state_checker.
module tb_planar_body_euler_step_unit;
    import pbe_pkg::*;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int PHASE_ITEMS   = 88;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [71:0]   s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;
    logic          cfg_wr_en;
    logic [1:0]    cfg_index;
    logic [30:0]   cfg_wdata;
    int            fail_count;
    int            pending;
    int            burst_left;

    planar_body_euler_step_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    body_state_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    // The output side switches at random between four stall modes.
    initial begin
        int mode;
        int left;
        left = 0;
        mode = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (left % 16 == 0);
            endcase
        end
    end

    function automatic logic [31:0] pick_value();
        logic [31:0] mag;
        logic [31:0] corner [6];
        corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return corner[$urandom_range(0, 5)];
            2: mag = $urandom_range(0, 32'h0400_0000);
            default: mag = $urandom_range(0, 32'h0010_0000);
        endcase
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // Items go out in bursts; valid stays high from one item to the next inside a burst.
    task automatic send_item(input op_t op, input logic [31:0] vx, input logic [31:0] vy);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, vy, vx, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_body_regs(input logic [30:0] mass, input logic [30:0] mu,
                                   input logic [30:0] radius, input logic [30:0] height);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MASS;
        cfg_wdata <= mass;
        @(posedge aclk);
        cfg_index <= REG_FRICTION;
        cfg_wdata <= mu;
        @(posedge aclk);
        cfg_index <= REG_RADIUS;
        cfg_wdata <= radius;
        @(posedge aclk);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= height;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly trajectories: place the body, give it a velocity, then push it for a few steps.
    task automatic run_random(input int count);
        int          sent;
        int          steps;
        logic [31:0] fx;
        logic [31:0] fy;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) != 0) begin
                send_item(OP_LOAD_POS, pick_value(), pick_value());
                if ($urandom_range(0, 5) == 0) send_item(OP_LOAD_VEL, 32'd0, 32'd0);
                else send_item(OP_LOAD_VEL, pick_value(), pick_value());
                steps = $urandom_range(2, 8);
                fx = pick_value();
                fy = pick_value();
                repeat (steps) begin
                    if ($urandom_range(0, 2) == 0) begin
                        fx = pick_value();
                        fy = pick_value();
                    end
                    send_item(OP_STEP, fx, fy);
                end
                sent += steps + 2;
            end else begin
                send_item(op_t'($urandom_range(0, 3)), pick_value(), pick_value());
                sent++;
            end
        end
    endtask

    initial begin
        logic [30:0] body_regs [6][4];
        body_regs = '{
            '{31'd131072, 31'd19661, 31'd16384, 31'd32768},
            '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF},
            '{31'd0, 31'd0, 31'd0, 31'd0},
            '{31'd1, 31'd6554, 31'd65536, 31'd65536},
            '{31'd0, 31'd0, 31'd0, 31'd0},
            '{31'd32768, 31'd65536, 31'd131072, 31'd98304}
        };
        for (int k = 0; k < 4; k++) body_regs[4][k] = 31'($urandom_range(0, 32'h7FFF_FFFF));
        burst_left = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_MASS;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: unit mass, no friction and no drag.
        send_item(OP_STEP, 32'd0, 32'd0);
        send_item(OP_STEP, 32'h0001_0000, 32'hFFFF_0000);
        send_item(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_NONE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_LOAD_POS, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_LOAD_VEL, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_STEP, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_LOAD_VEL, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_STEP, 32'd0, 32'd0);
        send_item(OP_LOAD_VEL, 32'd0, 32'd0);
        send_item(OP_STEP, 32'd0, 32'd0);
        send_item(OP_LOAD_POS, 32'd0, 32'd0);
        send_item(OP_LOAD_VEL, 32'd1, 32'hFFFF_FFFF);
        send_item(OP_STEP, 32'd0, 32'd0);

        for (int k = 0; k < 6; k++) begin
            drain();
            write_body_regs(body_regs[k][0], body_regs[k][1], body_regs[k][2], body_regs[k][3]);
            if (k == 0) begin
                // Friction and drag along each axis, diagonally, and on a body at rest.
                send_item(OP_LOAD_VEL, 32'h0001_0000, 32'd0);
                send_item(OP_STEP, 32'd0, 32'd0);
                send_item(OP_LOAD_VEL, 32'd0, 32'hFFFF_0000);
                send_item(OP_STEP, 32'd0, 32'd0);
                send_item(OP_LOAD_VEL, 32'h0003_0000, 32'h0004_0000);
                send_item(OP_STEP, 32'h0001_0000, 32'h0001_0000);
                send_item(OP_LOAD_VEL, 32'd0, 32'd0);
                send_item(OP_STEP, 32'd100000, 32'd0);
            end
            run_random(PHASE_ITEMS);
        end

        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
